[rtl/core/ascf_pkg.sv]
// ascf_pkg: shared types and constants of the ASCII CAN frame receiver.
// Used by ascii_can_frame_receiver and ascf_token; depends on nothing.
`default_nettype none

package ascf_pkg;

    localparam int MAX_FRAME_CHARS_DEF = 64;
    localparam int MAX_DATA_BYTES_DEF  = 8;
    localparam int MIN_FRAME_CHARS     = 4;
    localparam int CFG_W               = 16;

    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic REG_ACPT_MASK = 1'b0;
    localparam logic REG_ACPT_ADDR = 1'b1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FILTER = 1'b1;

    typedef struct packed {
        logic [7:0] rx_char;
        logic       link_reset;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] device_id;
        logic [3:0]  byte_count;
        logic [7:0]  data_0;
        logic [7:0]  data_1;
        logic [7:0]  data_2;
        logic [7:0]  data_3;
        logic [7:0]  data_4;
        logic [7:0]  data_5;
        logic [7:0]  data_6;
        logic [7:0]  data_7;
        logic        filter_open;
    } out_item_t;

    typedef struct packed {
        logic        done;
        logic        ok;
        logic [15:0] value;
    } tok_evt_t;

endpackage

`default_nettype wire

[rtl/core/ascii_can_frame_receiver.sv]
// ascii_can_frame_receiver: top level, frame buffer control and parse sequencer.
// Depends on ascf_pkg, ascf_buf and ascf_token.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one received character
//   per transaction, or a link reset. Output channel (out_valid/out_stall/
//   out_data) carries a data frame or a filter-open report.
//   cfg_we/cfg_index/cfg_data write the acceptance mask (index 0) and the
//   acceptance address (index 1); write only while the block is idle.
//   Ordinary characters are taken in one cycle each while the sequencer is idle.
//   On '>' with more than 4 buffered characters the sequencer walks the
//   buffer through the single memory read port and the shared token unit:
//   each visited character is read (ST_FETCH) and then evaluated (ST_EXEC),
//   over at most count+1 positions, and the output register is loaded in ST_EMIT.
//   in_stall is high from the walk until the result is in the output register.
//   A result waits in the output register while out_stall is high; new
//   characters are still taken then, and a following parse waits for it.
//   Reset clears the buffer count, overflow and filter flags, the
//   configuration and the output valid flag; the memory and the output
//   data are not cleared.
`default_nettype none

module ascii_can_frame_receiver #(
    parameter int MAX_FRAME_CHARS = ascf_pkg::MAX_FRAME_CHARS_DEF,
    parameter int MAX_DATA_BYTES  = ascf_pkg::MAX_DATA_BYTES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire ascf_pkg::in_item_t      in_data,
    output logic                         out_valid,
    input  wire                          out_stall,
    output ascf_pkg::out_item_t          out_data,
    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire [ascf_pkg::CFG_W-1:0]    cfg_data
);

    localparam int CW = $clog2(MAX_FRAME_CHARS + 1);
    localparam int AW = $clog2(MAX_FRAME_CHARS);

    typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_EMIT} state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                fopen_reg, fopen_next;
    logic [15:0]         mask_reg, mask_next;
    logic [15:0]         addr_reg, addr_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                scan_reg, scan_next;
    logic                isf_reg, isf_next;
    logic                first_reg, first_next;
    logic [15:0]         a_reg, a_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [7:0]          bytes_reg [8];
    logic [7:0]          bytes_next [8];
    logic                ekind_reg, ekind_next;
    logic                out_valid_reg, out_valid_next;
    ascf_pkg::out_item_t out_reg, out_next;

    logic                in_accept, mem_we, at_end, tok_en, tok_clear;
    logic                fin_none, fin_emit;
    logic [7:0]          rd_data, ch;
    ascf_pkg::tok_evt_t  tok;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign mem_we = in_accept && !in_data.link_reset && !ovf_reg
                    && (in_data.rx_char != ascf_pkg::CH_OPEN)
                    && (in_data.rx_char != ascf_pkg::CH_CLOSE)
                    && (count_reg < CW'(MAX_FRAME_CHARS));
    assign at_end = (idx_reg == count_reg);
    assign ch     = at_end ? ascf_pkg::CH_SPACE : rd_data;
    assign tok_en = (state_reg == ST_EXEC) && !scan_reg;

    ascf_buf #(
        .DEPTH (MAX_FRAME_CHARS)
    ) u_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_data.rx_char),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    ascf_token u_tok (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (tok_clear),
        .en    (tok_en),
        .ch    (ch),
        .evt   (tok)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        fopen_next     = fopen_reg;
        mask_next      = mask_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;
        isf_next       = isf_reg;
        first_next     = first_reg;
        a_next         = a_reg;
        cnt_next       = cnt_reg;
        bytes_next     = bytes_reg;
        ekind_next     = ekind_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        tok_clear      = 1'b0;
        fin_none       = 1'b0;
        fin_emit       = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                ascf_pkg::REG_ACPT_MASK: mask_next = cfg_data;
                ascf_pkg::REG_ACPT_ADDR: addr_next = cfg_data;
                default:                 mask_next = mask_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.link_reset)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        fopen_next = 1'b0;
                    end
                    else if (in_data.rx_char == ascf_pkg::CH_OPEN)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else if (in_data.rx_char == ascf_pkg::CH_CLOSE)
                    begin
                        if (ovf_reg)
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        else if (count_reg > CW'(ascf_pkg::MIN_FRAME_CHARS))
                        begin
                            state_next = ST_FETCH;
                            idx_next   = '0;
                            scan_next  = 1'b1;
                            first_next = 1'b0;
                            cnt_next   = 4'd0;
                            tok_clear  = 1'b1;
                            for (int i = 0; i < 8; i++)
                                bytes_next[i] = 8'd0;
                        end
                    end
                    else if (!ovf_reg)
                    begin
                        if (count_reg < CW'(MAX_FRAME_CHARS))
                            count_next = count_reg + CW'(1);
                        else
                            ovf_next = 1'b1;
                    end
                end
            end

            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                if (scan_reg)
                begin
                    if ((ch == ascf_pkg::CH_F) || (ch == ascf_pkg::CH_D))
                    begin
                        scan_next = 1'b0;
                        isf_next  = (ch == ascf_pkg::CH_F);
                    end
                    else if (at_end)
                        fin_none = 1'b1;
                end
                else
                begin
                    if (tok.done)
                    begin
                        if (!first_reg)
                        begin
                            if (!tok.ok)
                                fin_none = 1'b1;
                            else
                            begin
                                a_next     = tok.value;
                                first_next = 1'b1;
                            end
                        end
                        else if (isf_reg)
                        begin
                            if (tok.ok && (a_reg == mask_reg) && (tok.value == addr_reg))
                            begin
                                fin_emit   = 1'b1;
                                ekind_next = ascf_pkg::KIND_FILTER;
                                fopen_next = 1'b1;
                            end
                            else
                                fin_none = 1'b1;
                        end
                        else if (tok.ok)
                        begin
                            bytes_next[cnt_reg[2:0]] = tok.value[7:0];
                            cnt_next = cnt_reg + 4'd1;
                            if (cnt_next == 4'(MAX_DATA_BYTES))
                            begin
                                fin_emit   = 1'b1;
                                ekind_next = ascf_pkg::KIND_DATA;
                            end
                        end
                        else if (cnt_reg != 4'd0)
                        begin
                            fin_emit   = 1'b1;
                            ekind_next = ascf_pkg::KIND_DATA;
                        end
                        else
                            fin_none = 1'b1;
                    end
                    if (!fin_none && !fin_emit && at_end)
                    begin
                        if (!isf_reg && first_next && (cnt_next != 4'd0))
                        begin
                            fin_emit   = 1'b1;
                            ekind_next = ascf_pkg::KIND_DATA;
                        end
                        else
                            fin_none = 1'b1;
                    end
                end

                if (fin_none)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                end
                else if (fin_emit)
                begin
                    state_next = ST_EMIT;
                    count_next = '0;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_FETCH;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.kind  = ekind_reg;
                    if (ekind_reg == ascf_pkg::KIND_FILTER)
                        out_next.filter_open = 1'b1;
                    else
                    begin
                        out_next.device_id   = a_reg & ~mask_reg;
                        out_next.byte_count  = cnt_reg;
                        out_next.data_0      = bytes_reg[0];
                        out_next.data_1      = bytes_reg[1];
                        out_next.data_2      = bytes_reg[2];
                        out_next.data_3      = bytes_reg[3];
                        out_next.data_4      = bytes_reg[4];
                        out_next.data_5      = bytes_reg[5];
                        out_next.data_6      = bytes_reg[6];
                        out_next.data_7      = bytes_reg[7];
                        out_next.filter_open = fopen_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            fopen_reg     <= 1'b0;
            mask_reg      <= 16'd0;
            addr_reg      <= 16'd0;
            idx_reg       <= '0;
            scan_reg      <= 1'b0;
            isf_reg       <= 1'b0;
            first_reg     <= 1'b0;
            cnt_reg       <= 4'd0;
            ekind_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            fopen_reg     <= fopen_next;
            mask_reg      <= mask_next;
            addr_reg      <= addr_next;
            idx_reg       <= idx_next;
            scan_reg      <= scan_next;
            isf_reg       <= isf_next;
            first_reg     <= first_next;
            cnt_reg       <= cnt_next;
            ekind_reg     <= ekind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        bytes_reg <= bytes_next;
        out_reg   <= out_next;
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(MAX_DATA_BYTES))
        else $error("data byte count beyond limit");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_FRAME_CHARS))
        else $error("frame character count beyond buffer depth");

    a_filter_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.kind == ascf_pkg::KIND_FILTER)) |->
        ((out_data.byte_count == 4'd0) && out_data.filter_open))
        else $error("filter report carries data");

    a_link_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.link_reset) |=> (!fopen_reg && (count_reg == '0)))
        else $error("link reset did not clear state");

endmodule

`default_nettype wire

[rtl/core/ascf_buf.sv]
// ascf_buf: frame character memory, one write and one registered read port.
// Depends on nothing.
`default_nettype none

module ascf_buf #(
    parameter int DEPTH = 64
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [7:0]                 wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [7:0]                rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/ascf_token.sv]
// ascf_token: shared token evaluator, one character per step, hex and decimal.
// Depends on ascf_pkg.
`default_nettype none

module ascf_token (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   clear,
    input  wire                   en,
    input  wire [7:0]             ch,
    output ascf_pkg::tok_evt_t    evt
);

    logic        in_tok_reg, in_tok_next;
    logic [1:0]  pos_reg, pos_next;
    logic        fz_reg, fz_next;
    logic        hasx_reg, hasx_next;
    logic [15:0] hv_reg, hv_next;
    logic        hdig_reg, hdig_next;
    logic        hbad_reg, hbad_next;
    logic [15:0] dv_reg, dv_next;
    logic        dbad_reg, dbad_next;

    logic        is_space, is_x, is_dig, is_hex;
    logic [3:0]  hval;
    logic [19:0] dprod;

    always_comb
    begin
        is_space = (ch == ascf_pkg::CH_SPACE);
        is_x     = (ch == 8'h78) || (ch == 8'h58);
        is_dig   = (ch >= 8'h30) && (ch <= 8'h39);
        hval     = 4'd0;
        is_hex   = 1'b1;
        if (is_dig)
            hval = 4'(ch - 8'h30);
        else if ((ch >= 8'h61) && (ch <= 8'h66))
            hval = 4'(ch - 8'h57);
        else if ((ch >= 8'h41) && (ch <= 8'h46))
            hval = 4'(ch - 8'h37);
        else
            is_hex = 1'b0;
        dprod = {1'b0, dv_reg, 3'b000} + {3'b000, dv_reg, 1'b0} + {16'd0, hval};

        evt.done  = en && is_space && in_tok_reg;
        evt.ok    = hasx_reg ? (!hbad_reg && hdig_reg) : 1'b1;
        evt.value = hasx_reg ? hv_reg : (dbad_reg ? 16'd0 : dv_reg);

        in_tok_next = in_tok_reg;
        pos_next    = pos_reg;
        fz_next     = fz_reg;
        hasx_next   = hasx_reg;
        hv_next     = hv_reg;
        hdig_next   = hdig_reg;
        hbad_next   = hbad_reg;
        dv_next     = dv_reg;
        dbad_next   = dbad_reg;

        if (clear || (en && is_space))
        begin
            in_tok_next = 1'b0;
            pos_next    = 2'd0;
            fz_next     = 1'b0;
            hasx_next   = 1'b0;
            hv_next     = 16'd0;
            hdig_next   = 1'b0;
            hbad_next   = 1'b0;
            dv_next     = 16'd0;
            dbad_next   = 1'b0;
        end
        else if (en)
        begin
            in_tok_next = 1'b1;
            pos_next    = (pos_reg == 2'd2) ? pos_reg : pos_reg + 2'd1;
            if (pos_reg == 2'd0)
                fz_next = (ch == 8'h30);
            if (is_x)
                hasx_next = 1'b1;
            // hex: optional 0x prefix, then digits up to 16 bits
            if ((pos_reg == 2'd1) && fz_reg && is_x)
            begin
                hv_next   = 16'd0;
                hdig_next = 1'b0;
            end
            else if (!is_hex || (hv_reg[15:12] != 4'd0))
                hbad_next = 1'b1;
            else
            begin
                hv_next   = {hv_reg[11:0], hval};
                hdig_next = 1'b1;
            end
            // decimal: all digits, at most 65535
            if (!is_dig || (dprod > 20'd65535))
                dbad_next = 1'b1;
            else
                dv_next = dprod[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tok_reg <= 1'b0;
            pos_reg    <= 2'd0;
            fz_reg     <= 1'b0;
            hasx_reg   <= 1'b0;
            hv_reg     <= 16'd0;
            hdig_reg   <= 1'b0;
            hbad_reg   <= 1'b0;
            dv_reg     <= 16'd0;
            dbad_reg   <= 1'b0;
        end
        else
        begin
            in_tok_reg <= in_tok_next;
            pos_reg    <= pos_next;
            fz_reg     <= fz_next;
            hasx_reg   <= hasx_next;
            hv_reg     <= hv_next;
            hdig_reg   <= hdig_next;
            hbad_reg   <= hbad_next;
            dv_reg     <= dv_next;
            dbad_reg   <= dbad_next;
        end
    end

endmodule

`default_nettype wire

[test/tb_ascii_can_frame_receiver.sv]
// tb_ascii_can_frame_receiver: self-checking testbench of the ASCII CAN frame receiver.
// Drives character transactions from a queue, predicts frame results and checks them.
// Depends on ascf_pkg and ascii_can_frame_receiver.
`default_nettype none

module tb_ascii_can_frame_receiver;

    localparam int BUF_DEPTH   = ascf_pkg::MAX_FRAME_CHARS_DEF;
    localparam int BYTE_MAX    = ascf_pkg::MAX_DATA_BYTES_DEF;
    localparam int PHASE_ITEMS = 265;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    ascf_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ascf_pkg::out_item_t out_data;
    logic                cfg_we = 1'b0;
    logic                cfg_index = ascf_pkg::REG_ACPT_MASK;
    logic [15:0]         cfg_data = '0;

    ascii_can_frame_receiver uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [7:0]  frame_chars [BUF_DEPTH];
    int          frame_len;
    bit          frame_ovf;
    bit          filt_open;
    logic [15:0] mask_reg;
    logic [15:0] addr_reg;

    ascf_pkg::in_item_t  pending_chars [$];
    ascf_pkg::out_item_t expected_frames [$];
    int          errors;
    int          idle_pct;
    int          hold_cycles;
    bit          hold_req;
    bit          in_fire = 1'b0;
    int          pushed = 0;

    function automatic logic [7:0] char_at(int pos);
        if (pos < frame_len)
            return frame_chars[pos];
        return ascf_pkg::CH_SPACE;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic scan_token(inout int pos, output bit ok, output logic [15:0] val);
        int len;
        int start;
        int q;
        int d;
        bit hexed;
        int unsigned v;
        len = frame_len + 1;
        ok = 0;
        val = 0;
        v = 0;
        hexed = 0;
        while (pos < len && char_at(pos) == ascf_pkg::CH_SPACE) pos++;
        start = pos;
        while (pos < len && char_at(pos) != ascf_pkg::CH_SPACE)
        begin
            if (char_at(pos) == "x" || char_at(pos) == "X") hexed = 1;
            pos++;
        end
        if (pos >= len || pos == start) return;
        q = start;
        if (hexed)
        begin
            if (pos - q >= 2 && char_at(q) == "0" &&
                (char_at(q + 1) == "x" || char_at(q + 1) == "X"))
                q += 2;
            if (q == pos) return;
            for (; q < pos; q++)
            begin
                d = hex_digit(char_at(q));
                if (d < 0) return;
                v = (v << 4) | d;
                if (v > 32'hFFFF) return;
            end
            ok = 1;
            val = v[15:0];
            return;
        end
        ok = 1;
        for (; q < pos; q++)
        begin
            if (char_at(q) < "0" || char_at(q) > "9") return;
            v = v * 10 + (char_at(q) - "0");
            if (v > 32'hFFFF) return;
        end
        val = v[15:0];
    endtask

    task automatic parse_frame_text();
        int len;
        int p;
        int cnt;
        bit found;
        bit is_filter;
        bit ok;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] v;
        logic [7:0] bytes [BYTE_MAX];
        ascf_pkg::out_item_t r;
        len = frame_len + 1;
        found = 0;
        is_filter = 0;
        cnt = 0;
        for (p = 0; p < len; p++)
        begin
            if (char_at(p) == ascf_pkg::CH_F || char_at(p) == ascf_pkg::CH_D)
            begin
                is_filter = (char_at(p) == ascf_pkg::CH_F);
                found = 1;
                p++;
                break;
            end
        end
        if (!found) return;
        r = '0;
        if (is_filter)
        begin
            scan_token(p, ok, a);
            if (!ok) return;
            scan_token(p, ok, b);
            if (!ok) return;
            if (a != mask_reg || b != addr_reg) return;
            filt_open = 1;
            r.kind = ascf_pkg::KIND_FILTER;
            r.filter_open = 1'b1;
            expected_frames.push_back(r);
            return;
        end
        for (int i = 0; i < BYTE_MAX; i++) bytes[i] = 0;
        scan_token(p, ok, a);
        if (!ok) return;
        while (p < len && cnt < BYTE_MAX)
        begin
            scan_token(p, ok, v);
            if (!ok) break;
            bytes[cnt] = v[7:0];
            cnt++;
            p++;
        end
        if (cnt == 0) return;
        r.kind = ascf_pkg::KIND_DATA;
        r.device_id = a & ~mask_reg;
        r.byte_count = 4'(cnt);
        r.data_0 = bytes[0]; r.data_1 = bytes[1]; r.data_2 = bytes[2]; r.data_3 = bytes[3];
        r.data_4 = bytes[4]; r.data_5 = bytes[5]; r.data_6 = bytes[6]; r.data_7 = bytes[7];
        r.filter_open = filt_open;
        expected_frames.push_back(r);
    endtask

    task automatic predict_char(ascf_pkg::in_item_t it);
        if (it.link_reset)
        begin
            frame_len = 0;
            frame_ovf = 0;
            filt_open = 0;
        end
        else if (it.rx_char == ascf_pkg::CH_OPEN)
        begin
            frame_len = 0;
            frame_ovf = 0;
        end
        else if (it.rx_char == ascf_pkg::CH_CLOSE)
        begin
            if (frame_ovf)
            begin
                frame_len = 0;
                frame_ovf = 0;
            end
            else if (frame_len > ascf_pkg::MIN_FRAME_CHARS)
            begin
                parse_frame_text();
                frame_len = 0;
            end
        end
        else if (!frame_ovf)
        begin
            if (frame_len < BUF_DEPTH)
            begin
                frame_chars[frame_len] = it.rx_char;
                frame_len++;
            end
            else
                frame_ovf = 1;
        end
    endtask

    task automatic report_mismatch(string what, ascf_pkg::out_item_t got,
                                   ascf_pkg::out_item_t want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // input acceptance seen at the rising edge
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                predict_char(in_data);
                void'(pending_chars.pop_front());
            end
            if (!in_valid || in_fire)
            begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_chars[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            out_stall <= 1'b1;
            if (hold_cycles > 0) hold_cycles--;
        end
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        ascf_pkg::out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
                report_mismatch("unexpected transaction", out_data, '0);
            else
            begin
                e = expected_frames.pop_front();
                if (out_data !== e)
                    report_mismatch("transaction", out_data, e);
            end
        end
    end

    task automatic push_item(ascf_pkg::in_item_t it);
        pending_chars.push_back(it);
        pushed++;
    endtask

    task automatic push_char(logic [7:0] c);
        ascf_pkg::in_item_t it;
        it.rx_char = c;
        it.link_reset = 1'b0;
        push_item(it);
    endtask

    task automatic push_link_reset();
        ascf_pkg::in_item_t it;
        it.rx_char = 8'hFF;
        it.link_reset = 1'b1;
        push_item(it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    function automatic string rand_number(bit valid_hex);
        int unsigned v;
        int sel;
        string s;
        v = $urandom_range(9) < 7 ? $urandom_range(255) : $urandom_range(70000);
        sel = $urandom_range(9);
        if (sel < 4) s = $sformatf("%0d", v);
        else if (sel < 7) s = $sformatf("0x%0h", v);
        else if (sel < 8) s = $sformatf("%0hX", v);
        else if (sel < 9) s = $sformatf("%0dq", v);
        else s = valid_hex ? $sformatf("0X%0H", v) : "0xg1";
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_chars.size() > 0 || in_valid || expected_frames.size() > 0)
            @(posedge clk);
        repeat (2 * BUF_DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == ascf_pkg::REG_ACPT_MASK) mask_reg = val;
        else addr_reg = val;
    endtask

    task automatic random_frame();
        string s;
        int n;
        ascf_pkg::in_item_t it;
        s = "";
        if ($urandom_range(9) < 8)
        begin
            if ($urandom_range(3) == 0)
                s = $sformatf("F %s %s",
                    $urandom_range(2) ? $sformatf("%0d", mask_reg) : rand_number(1'b1),
                    $urandom_range(2) ? $sformatf("0x%0h", addr_reg) : rand_number(1'b1));
            else
            begin
                if ($urandom_range(4) == 0)
                    s = "xD ";
                else
                    s = "D ";
                s = {s, rand_number(1'b1)};
                n = $urandom_range(10);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(3) == 0)
                        s = {s, "  "};
                    else
                        s = {s, " "};
                    s = {s, rand_number($urandom_range(5) > 0)};
                end
            end
            push_char(ascf_pkg::CH_OPEN);
            push_text(s);
            push_char(ascf_pkg::CH_CLOSE);
        end
        else
        begin
            n = $urandom_range(12);
            for (int i = 0; i < n; i++)
            begin
                it.rx_char = 8'($urandom);
                it.link_reset = ($urandom_range(15) == 0);
                push_item(it);
            end
        end
    endtask

    initial
    begin
        int phase_start;
        errors = 0;
        frame_len = 0;
        frame_ovf = 0;
        filt_open = 0;
        mask_reg = 0;
        addr_reg = 0;
        idle_pct = 18;
        hold_req = 0;
        hold_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: default config, extremes, short frame, overflow, link reset
        push_text("<F 0 0>");
        push_text("<D 65535 255 0 0xff 1 2 3 4 5 6 7>");
        push_text("<D 0x1 1>");
        push_text("<Dab>");
        push_text("<D 0x10000 5>");
        push_text("<D 5 0xzz>");
        push_text("<D 70000 300 abc>");
        push_text("<abc>");
        push_text("<no frame here>");
        for (int i = 0; i < 70; i++) push_char("1");
        push_text("><D 1 2>");
        push_link_reset();
        push_text("<D 9 9>");
        wait_drained();

        write_reg(ascf_pkg::REG_ACPT_MASK, 16'hFFFF);
        write_reg(ascf_pkg::REG_ACPT_ADDR, 16'hFFFF);
        push_text("<F 0xffff 65535><D 0xABCD 1 2>");
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(ascf_pkg::REG_ACPT_MASK, (phase == 5) ? 16'h0000 : 16'($urandom));
            write_reg(ascf_pkg::REG_ACPT_ADDR, (phase == 5) ? 16'hFFFF : 16'($urandom));
            idle_pct = (phase == 2) ? 0 : 18;
            phase_start = pushed;
            while (pushed - phase_start < PHASE_ITEMS)
            begin
                while (pending_chars.size() > 40) @(posedge clk);
                random_frame();
            end
            if (phase == 3)
            begin
                hold_cycles = 400;
                hold_req = 1;
                push_text("<D 1 2><D 3 4><D 5 6><D 7 8>");
                while (hold_cycles > 0) @(posedge clk);
                hold_req = 0;
            end
            wait_drained();
        end

        wait_drained();
        if (errors == 0)
            $display("** ascii_can_frame_receiver: PASSED **");
        else
            $display("** ascii_can_frame_receiver: FAILED **");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("** ascii_can_frame_receiver: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
